// ===== hdl/srtf_pkg.sv =====
// Shared types and constants of the SRTF scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int COUNT_W = 7;   // width of process_count and of the slot counters
    localparam int ID_W    = 16;  // task identifier width
    localparam int FIELD_W = 16;  // width of arrival and burst on the input port
    localparam int SLOT_W  = 6;   // width of the slot field
    localparam int CLOCK_W = 32;  // scheduler time width

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

endpackage

// ===== hdl/srtf_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler.
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time-first scheduler. The task table lives in
// one synchronous memory (arrival, id, remaining per slot) with one write
// port and a registered read port; a row of per-slot loaded bits, cleared by
// reset, makes every slot read as finished until it is loaded. A load beat
// (mode 0) writes one slot in the cycle it is accepted and returns no result
// beat. A tick beat (mode 1) scans the first min(process_count, SLOTS) slots
// through the memory read port, one slot per cycle, keeping the best candidate
// (least remaining time, lowest slot on a tie) and a count of finished slots
// in registers; once the read of the last slot has returned, the scan state
// hands over to the update state, which waits until the result register is
// free, then writes the decremented entry back and loads the result register.
// The block takes one beat at a time; a result waiting on m_ready does not
// block the next input beat until that beat's own result is due. Loads to
// slots at or above SLOTS are dropped, slots above 63 can never be loaded and
// count as finished, and arrival and burst are cut to TIME_BITS bits. When
// every slot in use is finished (also with a process count of zero) a tick
// reports all_done and changes nothing; a tick where tasks remain but none
// has arrived advances time and reports idle. process_count is to be written
// through cfg_wr_en / cfg_wr_data only while idle; the user is bound to this,
// and the block itself does not enforce it.

module srtf_scheduler #(
    parameter int SLOTS     = 64,
    parameter int TIME_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [srtf_pkg::COUNT_W-1:0]   cfg_wr_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [srtf_pkg::SLOT_W-1:0]    s_slot,
    input  logic [srtf_pkg::FIELD_W-1:0]   s_arrival,
    input  logic [srtf_pkg::ID_W-1:0]      s_task_id,
    input  logic [srtf_pkg::FIELD_W-1:0]   s_burst,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [srtf_pkg::CLOCK_W-1:0]   m_time_now,
    output logic [srtf_pkg::ID_W-1:0]      m_run_id,
    output logic                           m_idle,
    output logic                           m_job_done,
    output logic                           m_all_done
);

    localparam int CW        = srtf_pkg::COUNT_W;
    localparam int IDW       = srtf_pkg::ID_W;
    localparam int TW        = srtf_pkg::CLOCK_W;
    // only slots 0..63 are reachable through the slot field
    localparam int DEPTH     = (SLOTS < 64) ? SLOTS : 64;
    localparam int ABITS     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << ABITS;
    // table word: {arrival, id, remaining}
    localparam int W         = 2 * TIME_BITS + IDW;
    localparam int REM_LO    = 0;
    localparam int ID_LO     = TIME_BITS;
    localparam int ARR_LO    = TIME_BITS + IDW;

    srtf_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        pc_reg;
    logic [TW-1:0]        clock_time_reg;

    // task table
    logic [W-1:0]         mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] loaded_reg;

    logic                 mem_we;
    logic [ABITS-1:0]     mem_wa;
    logic [W-1:0]         mem_wd;

    // scan pipeline
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        issue_reg;
    logic                 rd_en;
    logic                 issue_in_range;
    logic                 rsp_vld_reg;
    logic                 rsp_inr_reg;
    logic                 rsp_loaded_reg;
    logic [W-1:0]         rsp_word_reg;
    logic [ABITS-1:0]     rsp_idx_reg;

    // running min and finished count
    logic [CW-1:0]        done_cnt_reg;
    logic                 have_pick_reg;
    logic [W-1:0]         best_word_reg;
    logic [ABITS-1:0]     best_idx_reg;

    logic [TIME_BITS-1:0] ev_rem;
    logic [TIME_BITS-1:0] ev_arr;
    logic [TIME_BITS-1:0] best_rem;
    logic                 ev_arrived;
    logic                 ev_take;

    logic                 in_fire;
    logic                 tick_fire;
    logic                 load_fire;
    logic                 slot_ok;
    logic [CW-1:0]        n_cap;

    logic                 out_free;
    logic                 upd_fire;
    logic                 all_done_c;
    logic                 run_c;
    logic [TIME_BITS-1:0] new_rem;

    logic                 m_valid_reg;
    logic [TW-1:0]        m_time_now_reg;
    logic [IDW-1:0]       m_run_id_reg;
    logic                 m_idle_reg;
    logic                 m_job_done_reg;
    logic                 m_all_done_reg;

    // ---------------- handshake and control ----------------
    assign s_ready   = (state_reg == srtf_pkg::ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign tick_fire = in_fire && (s_mode == srtf_pkg::MODE_TICK);
    assign slot_ok   = (CW'(s_slot) < CW'(DEPTH));
    assign load_fire = in_fire && (s_mode == srtf_pkg::MODE_LOAD) && slot_ok;

    // slots in use: a count above SLOTS acts as SLOTS
    assign n_cap = (32'(pc_reg) > SLOTS) ? CW'(SLOTS) : pc_reg;

    assign rd_en          = (state_reg == srtf_pkg::ST_SCAN) && (issue_reg < n_reg);
    assign issue_in_range = (issue_reg < CW'(DEPTH));

    assign out_free   = !m_valid_reg || m_ready;
    assign upd_fire   = (state_reg == srtf_pkg::ST_UPDATE) && out_free;
    assign all_done_c = (done_cnt_reg == n_reg);
    assign run_c      = !all_done_c && have_pick_reg;

    // ---------------- scan evaluation ----------------
    // a slot never loaded, or beyond the table, reads as finished
    assign ev_rem     = (rsp_inr_reg && rsp_loaded_reg) ? rsp_word_reg[REM_LO +: TIME_BITS]
                                                        : '0;
    assign ev_arr     = rsp_word_reg[ARR_LO +: TIME_BITS];
    assign best_rem   = best_word_reg[REM_LO +: TIME_BITS];
    assign ev_arrived = (TW'(ev_arr) <= clock_time_reg);
    // strict compare keeps the lowest slot on a tie
    assign ev_take    = rsp_vld_reg && (ev_rem != '0) && ev_arrived &&
                        (!have_pick_reg || (ev_rem < best_rem));

    assign new_rem = best_rem - TIME_BITS'(1);

    // ---------------- memory write port ----------------
    always_comb begin
        mem_we = 1'b0;
        mem_wa = s_slot[ABITS-1:0];
        mem_wd = {TIME_BITS'(s_arrival), s_task_id, TIME_BITS'(s_burst)};
        if (load_fire) begin
            mem_we = 1'b1;
        end else if (upd_fire && run_c) begin
            mem_we = 1'b1;
            mem_wa = best_idx_reg;
            mem_wd = {best_word_reg[W-1:ID_LO], new_rem};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rsp_word_reg   <= mem[issue_reg[ABITS-1:0]];
            rsp_loaded_reg <= loaded_reg[issue_reg[ABITS-1:0]];
            rsp_inr_reg    <= issue_in_range;
            rsp_idx_reg    <= issue_reg[ABITS-1:0];
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srtf_pkg::ST_IDLE: begin
                if (tick_fire) state_next = srtf_pkg::ST_SCAN;
            end
            srtf_pkg::ST_SCAN: begin
                if (!rd_en && !rsp_vld_reg) state_next = srtf_pkg::ST_UPDATE;
            end
            srtf_pkg::ST_UPDATE: begin
                if (out_free) state_next = srtf_pkg::ST_IDLE;
            end
            default: state_next = srtf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srtf_pkg::ST_IDLE;
            pc_reg         <= '0;
            clock_time_reg <= '0;
            loaded_reg     <= '0;
            rsp_vld_reg    <= 1'b0;
            issue_reg      <= '0;
            n_reg          <= '0;
            done_cnt_reg   <= '0;
            have_pick_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rsp_vld_reg <= rd_en;

            if (cfg_wr_en) pc_reg <= cfg_wr_data;

            if (load_fire) loaded_reg[s_slot[ABITS-1:0]] <= 1'b1;

            if (tick_fire) begin
                issue_reg     <= '0;
                n_reg         <= n_cap;
                done_cnt_reg  <= '0;
                have_pick_reg <= 1'b0;
            end else begin
                if (rd_en) issue_reg <= issue_reg + CW'(1);
                if (rsp_vld_reg && (ev_rem == '0)) done_cnt_reg <= done_cnt_reg + CW'(1);
                if (ev_take) have_pick_reg <= 1'b1;
            end

            if (upd_fire && !all_done_c) clock_time_reg <= clock_time_reg + TW'(1);

            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // candidate and result payload
    always_ff @(posedge aclk) begin
        if (ev_take) begin
            best_word_reg <= rsp_word_reg;
            best_idx_reg  <= rsp_idx_reg;
        end
        if (upd_fire) begin
            m_time_now_reg <= all_done_c ? clock_time_reg : clock_time_reg + TW'(1);
            m_run_id_reg   <= run_c ? best_word_reg[ID_LO +: IDW] : '0;
            m_idle_reg     <= !all_done_c && !have_pick_reg;
            m_job_done_reg <= run_c && (new_rem == '0);
            m_all_done_reg <= all_done_c;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_time_now = m_time_now_reg;
    assign m_run_id   = m_run_id_reg;
    assign m_idle     = m_idle_reg;
    assign m_job_done = m_job_done_reg;
    assign m_all_done = m_all_done_reg;

endmodule

// ===== hdl/srtf_checker.sv =====
// Port-level checks of the SRTF scheduler, bound to the top level.
`timescale 1ns / 1ps

module srtf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [srtf_pkg::CLOCK_W-1:0]   m_time_now,
    input logic [srtf_pkg::ID_W-1:0]      m_run_id,
    input logic                           m_idle,
    input logic                           m_job_done,
    input logic                           m_all_done
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_time_now) && $stable(m_run_id)
                                && $stable(m_idle) && $stable(m_job_done)
                                && $stable(m_all_done))
        else $error("stalled result beat changed");

    // at most one of idle, job_done, all_done
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_idle, m_job_done, m_all_done}) <= 1)
        else $error("conflicting result flags");

    // no task id on a beat where nothing ran
    a_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_idle || m_all_done) |-> m_run_id == '0)
        else $error("run_id set on idle or all_done beat");

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (.*);

// ===== verif/srtf_tb_pkg.sv =====
// Tick predictor and result scoreboard for the SRTF scheduler testbench.
`timescale 1ns / 1ps

package srtf_tb_pkg;

    import srtf_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int MAX_PRINTED = 100;   // keeps the log short if everything breaks

    typedef struct packed {
        logic [CLOCK_W-1:0] time_now;
        logic [ID_W-1:0]    run_id;
        logic               idle;
        logic               job_done;
        logic               all_done;
    } run_beat_t;

    class srtf_tick_checker;

        bit [FIELD_W-1:0] arrival_of [TABLE_SLOTS];
        bit [ID_W-1:0]    id_of      [TABLE_SLOTS];
        bit [FIELD_W-1:0] left_of    [TABLE_SLOTS];
        bit [CLOCK_W-1:0] sched_clock;
        bit [COUNT_W-1:0] proc_count;
        run_beat_t        expected_runs [$];
        int               mismatches;

        function new();
            sched_clock = '0;
            proc_count  = '0;
            mismatches  = 0;
            foreach (left_of[i]) begin
                left_of[i] = '0;
            end
        endfunction

        function void set_count(bit [COUNT_W-1:0] value);
            proc_count = value;
        endfunction

        function int slots_in_use();
            return (proc_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(proc_count);
        endfunction

        function bit tasks_finished();
            for (int i = 0; i < slots_in_use(); i++) begin
                if (left_of[i] != 0) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function int outstanding();
            return expected_runs.size();
        endfunction

        // One scheduler tick: least remaining time among arrived slots, lowest slot on a tie.
        function run_beat_t predict_tick();
            run_beat_t res;
            int        n;
            int        done;
            int        pick;
            res  = '0;
            n    = slots_in_use();
            done = 0;
            pick = -1;
            for (int i = 0; i < n; i++) begin
                if (left_of[i] == 0) begin
                    done++;
                end else if ({16'd0, arrival_of[i]} <= sched_clock) begin
                    if (pick < 0 || left_of[i] < left_of[pick]) begin
                        pick = i;
                    end
                end
            end
            if (done == n) begin
                res.time_now = sched_clock;
                res.all_done = 1'b1;
                return res;
            end
            sched_clock++;
            res.time_now = sched_clock;
            if (pick < 0) begin
                res.idle = 1'b1;
                return res;
            end
            left_of[pick]--;
            res.run_id   = id_of[pick];
            res.job_done = (left_of[pick] == 0);
            return res;
        endfunction

        function void note_beat(logic mode, logic [SLOT_W-1:0] slot,
                                logic [FIELD_W-1:0] arrival, logic [ID_W-1:0] id,
                                logic [FIELD_W-1:0] burst);
            if (mode == MODE_TICK) begin
                expected_runs.push_back(predict_tick());
            end else begin
                arrival_of[slot] = arrival;
                id_of[slot]      = id;
                left_of[slot]    = burst;
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED) begin
                $display("ERROR @%0t: %s", $time, msg);
            end
            mismatches++;
        endtask

        task check_run(run_beat_t got);
            run_beat_t want;
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected: time_now %0d id %h",
                                          got.time_now, got.run_id));
                return;
            end
            want = expected_runs.pop_front();
            if (got.time_now !== want.time_now) begin
                report_mismatch($sformatf("time_now %0d, expected %0d",
                                          got.time_now, want.time_now));
            end
            if (got.run_id !== want.run_id) begin
                report_mismatch($sformatf("run_id %h, expected %h at time %0d",
                                          got.run_id, want.run_id, want.time_now));
            end
            if (got.idle !== want.idle) begin
                report_mismatch($sformatf("idle %b, expected %b at time %0d",
                                          got.idle, want.idle, want.time_now));
            end
            if (got.job_done !== want.job_done) begin
                report_mismatch($sformatf("job_done %b, expected %b at time %0d",
                                          got.job_done, want.job_done, want.time_now));
            end
            if (got.all_done !== want.all_done) begin
                report_mismatch($sformatf("all_done %b, expected %b at time %0d",
                                          got.all_done, want.all_done, want.time_now));
            end
        endtask

    endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench of the SRTF scheduler: directed and random load/tick beats.
`timescale 1ns / 1ps

module tb_top;

    import srtf_pkg::*;
    import srtf_tb_pkg::*;

    localparam int RUN_ITEMS     = 1800;
    localparam int SETTLE_CYCLES = 16;    // a load beat is written to the table as it is accepted
    localparam int TAIL_CYCLES   = 80;
    localparam int TICK_CAP      = 400;   // bound on ticks per job (long bursts never end)

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_mode      = MODE_LOAD;
    logic [SLOT_W-1:0]   s_slot      = '0;
    logic [FIELD_W-1:0]  s_arrival   = '0;
    logic [ID_W-1:0]     s_task_id   = '0;
    logic [FIELD_W-1:0]  s_burst     = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [CLOCK_W-1:0]  m_time_now;
    logic [ID_W-1:0]     m_run_id;
    logic                m_idle;
    logic                m_job_done;
    logic                m_all_done;

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  beats_sent    = 0;
    srtf_tick_checker    runs;

    srtf_scheduler i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_slot      (s_slot),
        .s_arrival   (s_arrival),
        .s_task_id   (s_task_id),
        .s_burst     (s_burst),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_time_now  (m_time_now),
        .m_run_id    (m_run_id),
        .m_idle      (m_idle),
        .m_job_done  (m_job_done),
        .m_all_done  (m_all_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop; a healthy run ends far earlier.
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side backpressure, redrawn every cycle on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: every accepted beat goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            runs.check_run({m_time_now, m_run_id, m_idle, m_job_done, m_all_done});
        end
    end

    // Drives one input beat. Entered and left on a falling edge; the random
    // gap in front of it drops valid, otherwise valid stays high across beats.
    task automatic send_beat(input logic mode, input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_W-1:0] arrival, input logic [ID_W-1:0] id,
                             input logic [FIELD_W-1:0] burst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_slot    <= slot;
        s_arrival <= arrival;
        s_task_id <= id;
        s_burst   <= burst;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        runs.note_beat(mode, slot, arrival, id, burst);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Tick payload fields are don't-care; randomize them anyway.
    task automatic tick_once();
        send_beat(MODE_TICK, SLOT_W'($urandom), FIELD_W'($urandom), ID_W'($urandom),
                  FIELD_W'($urandom));
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [FIELD_W-1:0] arrival,
                             input logic [ID_W-1:0] id, input logic [FIELD_W-1:0] burst);
        send_beat(MODE_LOAD, slot, arrival, id, burst);
    endtask

    // Hold the sender until every tick has reported, then give a trailing
    // load beat time to land in the table.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (runs.outstanding() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // process_count is only written with the block drained.
    task automatic write_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        runs.set_count(value);
    endtask

    // One job: pick a process count, fill slots 0..min(n, 64)-1 with short tasks that
    // arrive soon, then tick until all are done. Along the way a few loads
    // preempt with shorter work or throw in noise (any slot, full-range fields).
    task automatic run_job();
        int n;
        int live;
        int max_burst;
        int sel;
        int ticks;
        int hold_at;
        sel = $urandom_range(99);
        if (sel < 5) begin
            n = 0;
            max_burst = 0;
        end else if (sel < 13) begin
            n = $urandom_range(64, 127);    // above 64 acts as 64
            max_burst = 2;
        end else begin
            n = $urandom_range(1, 12);
            max_burst = 6;
        end
        live    = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;
        hold_at = ($urandom_range(99) < 20) ? $urandom_range(1, 10) : -1;
        write_count(COUNT_W'(n));
        for (int s = 0; s < live; s++) begin
            load_slot(SLOT_W'(s), FIELD_W'(runs.sched_clock + $urandom_range(0, 5)),
                      ID_W'($urandom), FIELD_W'($urandom_range(0, max_burst)));
        end
        ticks = 0;
        while (!runs.tasks_finished() && ticks < TICK_CAP) begin
            sel = $urandom_range(99);
            if (sel < 6 && live > 0) begin
                // short task arriving now, likely to preempt
                load_slot(SLOT_W'($urandom_range(0, live - 1)), FIELD_W'(runs.sched_clock),
                          ID_W'($urandom), FIELD_W'($urandom_range(1, 3)));
            end else if (sel < 9) begin
                load_slot(SLOT_W'($urandom),
                          ($urandom_range(1)) ? FIELD_W'($urandom)
                                              : FIELD_W'(runs.sched_clock + $urandom_range(0, 3)),
                          ID_W'($urandom),
                          ($urandom_range(1)) ? FIELD_W'($urandom)
                                              : FIELD_W'($urandom_range(0, 4)));
            end else begin
                tick_once();
                ticks++;
                if (ticks == hold_at) begin
                    wait_idle();
                end
            end
        end
        // one or two extra ticks, which report all_done if the job finished within the tick cap
        repeat ($urandom_range(1, 2)) tick_once();
    endtask

    initial begin
        int directed_beats;
        runs = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        send_idle_pct = 19;
        recv_idle_pct = 60;
        write_count(COUNT_W'(0));
        tick_once();                                  // empty table: all_done, time stays 0
        write_count(COUNT_W'(3));
        load_slot(6'd0, 16'h0000, 16'hFFFF, 16'd2);
        load_slot(6'd1, 16'h0000, 16'h0000, 16'd0);   // zero burst: finished at load
        load_slot(6'd2, 16'hFFFF, 16'h1234, 16'hFFFF); // arrives far in the future
        tick_once();
        tick_once();                                  // slot 0 finishes
        tick_once();                                  // idle: work left, none arrived
        load_slot(6'd2, 16'h0000, 16'h5A5A, 16'd1);   // overwrite a live slot
        tick_once();
        tick_once();                                  // all_done
        load_slot(6'd0, 16'h0000, 16'h0001, 16'd3);
        load_slot(6'd1, 16'h0000, 16'h0002, 16'd3);
        tick_once();                                  // tie goes to slot 0
        load_slot(6'd2, 16'h0000, 16'h0003, 16'd1);   // shorter task preempts
        tick_once();
        tick_once();
        write_count(COUNT_W'(127));                   // clamps to all 64 slots
        load_slot(6'd63, 16'h0000, 16'hBEEF, 16'd1);
        tick_once();
        tick_once();
        directed_beats = beats_sent;

        // Random part in three idling regimes: sender light / receiver heavy,
        // then swapped, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (beats_sent < directed_beats + (phase + 1) * RUN_ITEMS / 3) begin
                run_job();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (runs.mismatches == 0 && runs.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/srtf_pkg.sv
hdl/srtf_scheduler.sv
hdl/srtf_checker.sv
verif/srtf_tb_pkg.sv
verif/tb_top.sv
